/* hw/rtl/erasure_stripe_fragment_split_macros.svh */
// Assertion macros for the fragment splitter RTL (used by esfs_back).
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ERASURE_STRIPE_FRAGMENT_SPLIT_MACROS_SVH
`define ERASURE_STRIPE_FRAGMENT_SPLIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ESFS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESFS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/esfs_pkg.sv */
// Shared constants for the erasure stripe fragment splitter.
// No dependencies; used by every module of the block.
`default_nettype none

package esfs_pkg;

    localparam int TAG_W           = 16;
    localparam int BLK_W           = 24;
    localparam int PART_W          = 4;
    localparam int CNT_W           = 5;
    localparam int QUOT_BITS       = 4;
    localparam int RESULT_LIMIT    = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int MAX_PARTS_DEF   = 16;
    localparam int OFFSET_BITS_DEF = 31;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(6);

endpackage

`default_nettype wire

/* hw/rtl/erasure_stripe_fragment_split.sv */
// The front pipeline takes one request every cycle, holding only while its last stage is
// full and the queue is full; the back drives one result per cycle while m_tready is high,
// one result for each part that a request touches.
// Sustained rate is set by the result register: one result per cycle while m_tready is high.
// Reset (aresetn low, synchronous) empties pipeline, queue and output, sets part count to 6.
`default_nettype none

module erasure_stripe_fragment_split #(
    parameter int MAX_DATA_PARTS = esfs_pkg::MAX_PARTS_DEF,
    parameter int OFFSET_BITS    = esfs_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Part count register write
    input  wire logic                       cfg_wr_en,
    input  wire logic [esfs_pkg::CNT_W-1:0] cfg_wr_data,
    // Request channel
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // request_tag, block_number, block_offset, byte_length, block_bytes (lowest first)
    input  wire logic [((esfs_pkg::TAG_W+esfs_pkg::BLK_W+3*OFFSET_BITS+7)/8)*8-1:0] s_tdata,
    // Result channel
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // tag_out, block_out, part_number, part_offset, part_length (lowest first)
    output logic [((esfs_pkg::TAG_W+esfs_pkg::BLK_W+esfs_pkg::PART_W
                    +2*OFFSET_BITS+7)/8)*8-1:0] m_tdata,
    // bad_request
    output logic                            m_tuser,
    // last_piece
    output logic                            m_tlast
);
    import esfs_pkg::*;

    localparam int W   = OFFSET_BITS;
    localparam int QW  = TAG_W + BLK_W + 1 + 2 * QUOT_BITS + 4 * W;
    localparam int O_B = TAG_W;
    localparam int O_O = TAG_W + BLK_W;

    logic [CNT_W-1:0] part_cnt_reg;
    logic             q_push, q_full, q_pop, q_nempty;
    logic [QW-1:0]    q_data, q_head;

    // Part count: the user must write it only while idle (not enforced here), so hold it plainly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_cnt_reg <= CNT_RESET;
        end else if (cfg_wr_en) begin
            part_cnt_reg <= cfg_wr_data;
        end
    end

    // Front: classify the request, size the parts, find the first and last part.
    esfs_front #(
        .MAX_DATA_PARTS (MAX_DATA_PARTS),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .part_count (part_cnt_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_tag     (s_tdata[TAG_W-1:0]),
        .in_blk     (s_tdata[O_B+BLK_W-1:O_B]),
        .in_off     (s_tdata[O_O+W-1:O_O]),
        .in_len     (s_tdata[O_O+2*W-1:O_O+W]),
        .in_size    (s_tdata[O_O+3*W-1:O_O+2*W]),
        .q_push     (q_push),
        .q_data     (q_data),
        .q_full     (q_full)
    );

    // Short queue: lets the front run on while the back walks a long request.
    esfs_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .nempty    (q_nempty),
        .head      (q_head)
    );

    // Back: advance one part per result, drop the request after its last piece.
    esfs_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_nempty (q_nempty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* hw/rtl/esfs_queue.sv */
// Small register FIFO between the classifying front and the emitting back.
// Takes its default depth from esfs_pkg.
`default_nettype none

module esfs_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = esfs_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   nempty,
    output logic [DATA_W-1:0]      head
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_QW'(DEPTH));
    assign nempty  = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && nempty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/esfs_front.sv */
// Front pipeline: validates a request, divides the block into part size and
// locates the first and last part touched. Depends on esfs_pkg.
`default_nettype none

module esfs_front #(
    parameter int MAX_DATA_PARTS = esfs_pkg::MAX_PARTS_DEF,
    parameter int OFFSET_BITS    = esfs_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [esfs_pkg::CNT_W-1:0]   part_count,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [esfs_pkg::TAG_W-1:0]   in_tag,
    input  wire logic [esfs_pkg::BLK_W-1:0]   in_blk,
    input  wire logic [OFFSET_BITS-1:0]       in_off,
    input  wire logic [OFFSET_BITS-1:0]       in_len,
    input  wire logic [OFFSET_BITS-1:0]       in_size,
    output logic                              q_push,
    output logic [esfs_pkg::TAG_W+esfs_pkg::BLK_W+1+2*esfs_pkg::QUOT_BITS
                  +4*OFFSET_BITS-1:0]         q_data,
    input  wire logic                         q_full
);
    import esfs_pkg::*;

    localparam int W     = OFFSET_BITS;
    localparam int DW    = W + 1;
    localparam int NDIV  = (DW + 7) / 8;
    localparam int DPW   = NDIV * 8;
    localparam int NS    = 1 + NDIV + QUOT_BITS;
    localparam int LIM_I = (MAX_DATA_PARTS < RESULT_LIMIT) ? MAX_DATA_PARTS : RESULT_LIMIT;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LIM_I);

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [BLK_W-1:0]     blk;
        logic                 bad;
        logic [QUOT_BITS-1:0] qf;
        logic [QUOT_BITS-1:0] ql;
        logic [W-1:0]         foff;
        logic [W-1:0]         rend;
        logic [W-1:0]         psize;
        logic [W-1:0]         len;
    } entry_t;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [BLK_W-1:0]     blk;
        logic                 bad;
        logic [W-1:0]         len;
        logic [CNT_W-1:0]     parts;
        logic [DPW-1:0]       dvd;
        logic [CNT_W-1:0]     rem;
        logic [DPW-1:0]       quo;
        logic [W+3:0]         roff;
        logic [W+3:0]         rend;
        logic [QUOT_BITS-1:0] qf;
        logic [QUOT_BITS-1:0] ql;
    } stage_t;

    stage_t         st_reg  [NS];
    stage_t         st_next [NS];
    logic [NS-1:0]  v_reg;
    logic           adv;
    entry_t         ent;

    // Whole pipeline moves together; it holds only when the queue is full and its last stage holds a request.
    assign adv      = !v_reg[NS-1] || !q_full;
    assign in_ready = adv;
    assign q_push   = v_reg[NS-1] && !q_full;

    always_comb begin
        stage_t             cur;
        logic [W:0]         sum;
        logic [CNT_W-1:0]   pc;
        logic [CNT_W:0]     r6;
        logic [W+3:0]       sh;
        logic               qb;

        // Entry stage: classify and set up the part size division.
        pc = part_count;
        if (pc == '0) begin
            pc = CNT_W'(1);
        end
        if (pc > LIMIT) begin
            pc = LIMIT;
        end
        sum = {1'b0, in_off} + {1'b0, in_len};
        cur = '0;
        cur.tag   = in_tag;
        cur.blk   = in_blk;
        cur.len   = in_len;
        cur.parts = pc;
        cur.bad   = (in_len == '0) || (in_size == '0) || (sum > {1'b0, in_size});
        cur.dvd   = DPW'({1'b0, in_size} + DW'(pc) - DW'(1));
        cur.roff  = (W + 4)'(in_off);
        cur.rend  = (W + 4)'(sum[W-1:0] - W'(1));
        st_next[0] = cur;

        for (int i = 1; i < NS; i++) begin
            cur = st_reg[i-1];
            if (i <= NDIV) begin
                // Eight quotient bits of ceil(size / parts) per stage.
                for (int b = 0; b < 8; b++) begin
                    r6      = {cur.rem, cur.dvd[DPW-1]};
                    cur.dvd = {cur.dvd[DPW-2:0], 1'b0};
                    qb      = (r6 >= {1'b0, cur.parts});
                    if (qb) begin
                        r6 = r6 - {1'b0, cur.parts};
                    end
                    cur.rem = r6[CNT_W-1:0];
                    cur.quo = {cur.quo[DPW-2:0], qb};
                end
            end else begin
                // One bit of the part index per stage, for both range ends.
                sh = (W + 4)'(cur.quo[W-1:0]) << (NS - 1 - i);
                if (cur.roff >= sh) begin
                    cur.roff = cur.roff - sh;
                    cur.qf[NS-1-i] = 1'b1;
                end
                if (cur.rend >= sh) begin
                    cur.rend = cur.rend - sh;
                    cur.ql[NS-1-i] = 1'b1;
                end
            end
            st_next[i] = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NS; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_comb begin
        ent.tag   = st_reg[NS-1].tag;
        ent.blk   = st_reg[NS-1].blk;
        ent.bad   = st_reg[NS-1].bad;
        ent.qf    = st_reg[NS-1].qf;
        ent.ql    = st_reg[NS-1].ql;
        ent.foff  = st_reg[NS-1].roff[W-1:0];
        ent.rend  = st_reg[NS-1].rend[W-1:0];
        ent.psize = st_reg[NS-1].quo[W-1:0];
        ent.len   = st_reg[NS-1].len;
    end

    assign q_data = ent;

endmodule

`default_nettype wire

/* hw/rtl/esfs_back.sv */
// Back end: walks the parts of each queued request and drives the result
// register. Depends on esfs_pkg and the assertion macro header.
`default_nettype none
`include "erasure_stripe_fragment_split_macros.svh"

module esfs_back #(
    parameter int OFFSET_BITS = esfs_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_nempty,
    input  wire logic [esfs_pkg::TAG_W+esfs_pkg::BLK_W+1+2*esfs_pkg::QUOT_BITS
                       +4*OFFSET_BITS-1:0]    q_head,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [((esfs_pkg::TAG_W+esfs_pkg::BLK_W+esfs_pkg::PART_W
                    +2*OFFSET_BITS+7)/8)*8-1:0] m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import esfs_pkg::*;

    localparam int W     = OFFSET_BITS;
    localparam int OUT_W = ((TAG_W + BLK_W + PART_W + 2 * W + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - (TAG_W + BLK_W + PART_W + 2 * W);

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [BLK_W-1:0]     blk;
        logic                 bad;
        logic [QUOT_BITS-1:0] qf;
        logic [QUOT_BITS-1:0] ql;
        logic [W-1:0]         foff;
        logic [W-1:0]         rend;
        logic [W-1:0]         psize;
        logic [W-1:0]         len;
    } entry_t;

    entry_t               h;
    logic                 mid_reg, mid_next;
    logic [QUOT_BITS-1:0] p_reg, p_next;
    logic [QUOT_BITS-1:0] cur;
    logic                 load, done;
    logic [PART_W-1:0]    pc_part;
    logic [W-1:0]         pc_off, pc_len;

    logic                 vld_reg, vld_next;
    logic [TAG_W-1:0]     tag_reg;
    logic [BLK_W-1:0]     blk_reg;
    logic [PART_W-1:0]    part_reg;
    logic [W-1:0]         off_reg, len_reg;
    logic                 bad_reg, last_reg;

    assign h    = q_head;
    assign cur  = mid_reg ? p_reg : h.qf;
    assign load = q_nempty && (!vld_reg || m_tready);
    assign done = h.bad || (cur == h.ql);
    assign q_pop = load && done;

    always_comb begin
        pc_part = PART_W'(cur);
        pc_off  = '0;
        pc_len  = h.psize;
        if (h.bad) begin
            pc_part = '0;
            pc_len  = '0;
        end else if (h.qf == h.ql) begin
            pc_off = h.foff;
            pc_len = h.len;
        end else if (cur == h.qf) begin
            pc_off = h.foff;
            pc_len = h.psize - h.foff;
        end else if (cur == h.ql) begin
            pc_len = h.rend + W'(1);
        end
    end

    always_comb begin
        mid_next = mid_reg;
        p_next   = p_reg;
        vld_next = vld_reg;
        if (m_tready) begin
            vld_next = 1'b0;
        end
        if (load) begin
            vld_next = 1'b1;
            mid_next = !done;
            p_next   = cur + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg <= 1'b0;
            p_reg   <= '0;
            vld_reg <= 1'b0;
        end else begin
            mid_reg <= mid_next;
            p_reg   <= p_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tag_reg  <= h.tag;
            blk_reg  <= h.blk;
            part_reg <= pc_part;
            off_reg  <= pc_off;
            len_reg  <= pc_len;
            bad_reg  <= h.bad;
            last_reg <= done;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, len_reg, off_reg, part_reg, blk_reg, tag_reg};
    assign m_tuser  = bad_reg;
    assign m_tlast  = last_reg;

    `ESFS_ASSERT_IMP(a_bad_is_single, vld_reg && bad_reg, last_reg && (len_reg == '0), "bad result not a lone zero piece")
    `ESFS_ASSERT_IMP(a_mid_has_head, mid_reg, q_nempty, "part walk without a queued request")
    `ESFS_ASSERT_NXT(a_walk_continues, load && !done, mid_reg && vld_reg, "part walk dropped early")

endmodule

`default_nettype wire

/* tb/erasure_stripe_fragment_split_tb.sv */
// Self-checking bench for the erasure stripe fragment splitter: directed table, then random
// requests, each result checked against a behavioural prediction of the part split.
// Depends on esfs_pkg and the erasure_stripe_fragment_split RTL.
`timescale 1ns / 100ps

module erasure_stripe_fragment_split_tb;
    import esfs_pkg::*;

    localparam int OFFB   = OFFSET_BITS_DEF;
    localparam int S_W    = ((TAG_W + BLK_W + 3*OFFB + 7)/8)*8;
    localparam int M_W    = ((TAG_W + BLK_W + PART_W + 2*OFFB + 7)/8)*8;
    localparam int N_DIR  = 22;
    localparam int N_RAND = 248;

    typedef struct packed {
        logic [OFFB-1:0]   bytes;
        logic [OFFB-1:0]   len;
        logic [OFFB-1:0]   off;
        logic [BLK_W-1:0]  blk;
        logic [TAG_W-1:0]  tag;
    } request_t;

    typedef struct packed {
        logic [OFFB-1:0]   plen;
        logic [OFFB-1:0]   poff;
        logic [PART_W-1:0] part;
        logic [BLK_W-1:0]  blk;
        logic [TAG_W-1:0]  tag;
        logic              bad;
        logic              last;
    } piece_t;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser, m_tlast;
    logic [S_W-1:0] s_tdata;
    logic [M_W-1:0] m_tdata;

    erasure_stripe_fragment_split u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // Our own copy of the part count register
    logic [CNT_W-1:0] part_count;
    piece_t pending_pieces[$];
    int errors = 0;
    int pieces_seen = 0;
    int requests_sent = 0;
    bit stall_free = 0;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("[erasure_stripe_fragment_split] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Append one predicted piece at the tail of the pending list
    task automatic queue_piece(input piece_t pc);
        pending_pieces.insert(pending_pieces.size(), pc);
    endtask

    // Split one request into the pieces the block should emit
    task automatic split_request(input request_t r);
        longint unsigned parts, psize, last_b, first, lastp, p;
        piece_t pc;
        pc = '0;
        pc.tag = r.tag;
        pc.blk = r.blk;
        pc.last = 1'b1;
        if (r.len == 0 || r.bytes == 0 ||
            longint'(r.off) + longint'(r.len) > longint'(r.bytes)) begin
            pc.bad = 1'b1;
            queue_piece(pc);
            return;
        end
        parts = (part_count == 0) ? 1 : part_count;
        if (parts > MAX_PARTS_DEF) parts = MAX_PARTS_DEF;
        psize = (r.bytes + parts - 1) / parts;
        last_b = longint'(r.off) + r.len - 1;
        first = r.off / psize;
        lastp = last_b / psize;
        if (first == lastp) begin
            pc.part = first[PART_W-1:0];
            pc.poff = OFFB'(r.off % psize);
            pc.plen = r.len;
            queue_piece(pc);
            return;
        end
        for (p = first; p <= lastp && p < first + RESULT_LIMIT; p++) begin
            pc.part = p[PART_W-1:0];
            pc.last = (p == lastp);
            if (p == first) begin
                pc.poff = OFFB'(r.off % psize);
                pc.plen = OFFB'(psize - r.off % psize);
            end else if (p == lastp) begin
                pc.poff = '0;
                pc.plen = OFFB'(last_b % psize + 1);
            end else begin
                pc.poff = '0;
                pc.plen = OFFB'(psize);
            end
            queue_piece(pc);
        end
    endtask

    // Check each result at the rising edge it is accepted
    always @(posedge aclk) begin
        piece_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[TAG_W+BLK_W+PART_W+2*OFFB-1:0], m_tuser, m_tlast};
            pieces_seen++;
            if (pending_pieces.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_pieces.pop_front();
                if (got.tag !== want.tag) report_mismatch("tag_out");
                if (got.blk !== want.blk) report_mismatch("block_out");
                if (got.part !== want.part) report_mismatch("part_number");
                if (got.poff !== want.poff) report_mismatch("part_offset");
                if (got.plen !== want.plen) report_mismatch("part_length");
                if (got.bad !== want.bad) report_mismatch("bad_request");
                if (got.last !== want.last) report_mismatch("last_piece");
            end
        end
    end

    // Result side stalls: mostly short, a few long, some stall-free stretches
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (stall_free || $urandom_range(0, 3) != 0) begin
                m_tready = 1;
            end else begin
                m_tready = 0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 2)) @(negedge aclk);
            end
        end
    end

    task automatic send_request(input request_t r);
        if ($urandom_range(0, 2) == 0)
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 25)
                                               : $urandom_range(1, 2)) @(negedge aclk);
        s_tdata = S_W'(r);
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        split_request(r);
        requests_sent++;
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    // Drain everything, then let the pipeline settle before touching the register
    task automatic drain_then_write(input logic [CNT_W-1:0] val);
        int guard;
        guard = 0;
        while (pending_pieces.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (20) @(negedge aclk);
        cfg_wr_data = val;
        cfg_wr_en = 1;
        @(negedge aclk);
        cfg_wr_en = 0;
        part_count = val;
    endtask

    function automatic request_t make_req(input longint unsigned off, len, bytes);
        request_t r;
        r.tag = 16'($urandom);
        r.blk = 24'($urandom);
        r.off = OFFB'(off);
        r.len = OFFB'(len);
        r.bytes = OFFB'(bytes);
        return r;
    endfunction

    // Random request: mostly valid ranges in small blocks, some large, some broken
    function automatic request_t random_req();
        longint unsigned bytes, off, len;
        int pick;
        pick = $urandom_range(0, 19);
        bytes = (pick < 2) ? $urandom_range(32'h7fff_fff0, 32'h7fff_ffff)
              : (pick < 6) ? 64'($urandom) & 64'h7fff_ffff
              : $urandom_range(1, 400);
        if (pick == 19) return make_req(64'($urandom) & 64'h7fff_ffff,
                                        64'($urandom) & 64'h7fff_ffff,
                                        64'($urandom) & 64'h7fff_ffff);
        if (pick == 18) return make_req($urandom_range(0, 50), 0, bytes);
        if (bytes == 0) bytes = 1;
        off = 64'($urandom) % bytes;
        len = 1 + 64'($urandom) % (bytes - off);
        if (pick == 17) len = bytes - off + 1 + $urandom_range(0, 3);
        return make_req(off, len, bytes);
    endfunction

    initial begin
        request_t r;
        request_t dir_reqs[N_DIR];
        bit       dir_known[N_DIR];
        piece_t   dir_want[N_DIR];
        logic [CNT_W-1:0] cfg_plan[6];
        int guard;

        aresetn = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        part_count = CNT_RESET;
        repeat (7) @(negedge aclk);
        aresetn = 1;

        // Directed table; rows with a hand-typed expectation are also cross-checked
        dir_reqs[0]  = '{bytes: 600, len: 0, off: 0, blk: 24'hffffff, tag: 16'hffff};
        dir_reqs[1]  = '{bytes: 0, len: 1, off: 0, blk: 0, tag: 0};
        dir_reqs[2]  = '{bytes: 10, len: 5, off: 6, blk: 1, tag: 2};
        dir_reqs[3]  = '{bytes: 600, len: 1, off: 0, blk: 3, tag: 4};
        dir_reqs[4]  = '{bytes: 600, len: 600, off: 0, blk: 5, tag: 6};
        dir_reqs[5]  = '{bytes: 600, len: 1, off: 599, blk: 7, tag: 8};
        dir_reqs[6]  = '{bytes: 600, len: 2, off: 99, blk: 9, tag: 10};
        dir_reqs[7]  = '{bytes: 601, len: 300, off: 50, blk: 11, tag: 12};
        dir_reqs[8]  = '{bytes: 31'h7fffffff, len: 31'h7fffffff, off: 0, blk: 13, tag: 14};
        dir_reqs[9]  = '{bytes: 31'h7fffffff, len: 1, off: 31'h7ffffffe, blk: 15, tag: 16};
        dir_reqs[10] = '{bytes: 31'h7fffffff, len: 31'h7fffffff, off: 31'h7fffffff,
                         blk: 24'haaaaaa, tag: 16'h5555};
        dir_reqs[11] = '{bytes: 5, len: 5, off: 0, blk: 24'h555555, tag: 16'haaaa};
        dir_reqs[12] = '{bytes: 7, len: 3, off: 2, blk: 17, tag: 18};
        dir_reqs[13] = '{bytes: 31'h40000000, len: 31'h3fffffff, off: 1, blk: 19, tag: 20};
        for (int i = 14; i < N_DIR; i++) dir_reqs[i] = random_req();
        for (int i = 0; i < N_DIR; i++) dir_known[i] = 0;
        // Errors read straight off the rules: zero length, zero size, range past the end
        dir_known[0] = 1; dir_want[0] = '{0, 0, 0, 24'hffffff, 16'hffff, 1, 1};
        dir_known[1] = 1; dir_want[1] = '{0, 0, 0, 0, 0, 1, 1};
        dir_known[2] = 1; dir_want[2] = '{0, 0, 0, 1, 2, 1, 1};
        // Right after reset six parts of 100 bytes: byte 0 is part 0, byte 599 part 5
        dir_known[3] = 1; dir_want[3] = '{1, 0, 0, 3, 4, 0, 1};
        dir_known[5] = 1; dir_want[5] = '{1, 99, 5, 7, 8, 0, 1};
        dir_known[10] = 1; dir_want[10] = '{0, 0, 0, 24'haaaaaa, 16'h5555, 1, 1};

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_known[i]) begin
                split_request(dir_reqs[i]);
                if (pending_pieces[$] !== dir_want[i]) report_mismatch("directed row table");
                void'(pending_pieces.pop_back());
            end
            send_request(dir_reqs[i]);
        end

        // Walk several part counts, the extremes and out-of-range values among them
        cfg_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17};
        for (int ph = 0; ph < 6; ph++) begin
            drain_then_write(cfg_plan[ph]);
            stall_free = (ph == 4);
            for (int i = 0; i < N_RAND / 6; i++) begin
                r = random_req();
                send_request(r);
            end
        end
        stall_free = 0;

        guard = 0;
        while (pending_pieces.size() != 0 && guard < 500000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (30) @(negedge aclk);
        $display("Sent %0d requests over part counts 6,1,16,0,31,3,17; checked %0d pieces.",
                 requests_sent, pieces_seen);
        if (errors == 0 && pending_pieces.size() == 0) begin
            $display("[erasure_stripe_fragment_split] OK");
        end else begin
            $display("[erasure_stripe_fragment_split] ERROR");
        end
        $finish;
    end
endmodule
